// ===== hdl/b2da_pkg.sv =====
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package b2da_pkg;

    localparam int VALUE_W    = 64;
    localparam int NUM_DIGITS = 20;
    localparam int BCD_W      = 4;
    localparam int CHAR_W     = 6;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);

    localparam logic [BIT_CNT_W-1:0] LAST_BIT   = BIT_CNT_W'(VALUE_W - 1);
    localparam logic [DIG_CNT_W-1:0] LAST_DIGIT = DIG_CNT_W'(NUM_DIGITS - 1);

    // ASCII '0' reduced to the character width.
    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
    // Digits of five or more get three added before each shift.
    localparam logic [BCD_W-1:0] DABBLE_LIMIT = BCD_W'(5);
    localparam logic [BCD_W-1:0] DABBLE_ADD   = BCD_W'(3);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } b2da_state_t;

    // Commands broadcast to every digit cell.
    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift_digit;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/binary_to_decimal_ascii_top.sv =====
// Top level of the binary to decimal ASCII converter: the binary shift
// register, the chain of BCD digit cells and the sequencer.
// Depends on b2da_pkg, b2da_cell and b2da_ctrl.
//
// Usage:
//   The input channel (s_valid, s_ready, s_value) takes one unsigned 64-bit
//   word. The result channel (m_valid, m_ready, m_digit_char, m_is_last)
//   returns the decimal text of that word as ASCII digits, most significant
//   first, with leading zeros dropped; zero gives a single '0'. The final
//   digit of each run has m_is_last set. A run is 1 to 20 words long.
//   Conversion is double dabble in a row of 20 digit cells: for each input
//   bit every cell corrects its digit and shifts one bit to its upper neighbor.
//   The cells then shift whole digits upward, one per cycle unless a shown
//   digit waits for a stalled receiver, and the top cell feeds the output
//   register. A new word is accepted while the last digit of the previous
//   one still waits in the output register. If the receiver stalls, the digit
//   chain holds until the output register frees up; nothing is lost.
//   Reset (aresetn low, synchronous) returns the sequencer to idle and drops
//   any pending output word.
`default_nettype none

module binary_to_decimal_ascii_top (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [b2da_pkg::VALUE_W-1:0] s_value,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [b2da_pkg::CHAR_W-1:0]  m_digit_char,
    output logic                         m_is_last
);
    import b2da_pkg::*;

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic               load_value;
    logic               shift_value;
    cell_ctrl_t         cell_ctrl;

    // Bit carry between cells; the carry out of the top cell is always zero.
    logic [NUM_DIGITS:0]  carry;
    logic [BCD_W-1:0]     digits [NUM_DIGITS];

    // The binary word shifts out MSB first into the lowest digit cell.
    always_comb begin
        value_next = value_reg;
        if (load_value) begin
            value_next = s_value;
        end else if (shift_value) begin
            value_next = {value_reg[VALUE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign carry[0] = value_reg[VALUE_W-1];

    for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
        logic [BCD_W-1:0] lower_digit;
        if (i == 0) begin : g_first
            assign lower_digit = '0;
        end else begin : g_rest
            assign lower_digit = digits[i-1];
        end
        b2da_cell u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl),
            .bit_in    (carry[i]),
            .digit_in  (lower_digit),
            .bit_out   (carry[i+1]),
            .digit_out (digits[i])
        );
    end

    b2da_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .top_digit    (digits[NUM_DIGITS-1]),
        .cell_ctrl    (cell_ctrl),
        .load_value   (load_value),
        .shift_value  (shift_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_is_last    (m_is_last)
    );

endmodule

`default_nettype wire

// ===== hdl/b2da_cell.sv =====
// One BCD digit cell of the double dabble chain.
// Depends on b2da_pkg for the digit width and the command struct.
`default_nettype none

module b2da_cell (
    input  wire                         aclk,
    input  wire  b2da_pkg::cell_ctrl_t  ctrl,
    input  wire                         bit_in,
    input  wire  [b2da_pkg::BCD_W-1:0]  digit_in,
    output logic                        bit_out,
    output logic [b2da_pkg::BCD_W-1:0]  digit_out
);
    import b2da_pkg::*;

    logic [BCD_W-1:0] digit_reg;
    logic [BCD_W-1:0] digit_next;
    logic [BCD_W-1:0] corrected;

    // Correct before shifting so the digit never exceeds nine after the shift.
    assign corrected = (digit_reg >= DABBLE_LIMIT) ? digit_reg + DABBLE_ADD : digit_reg;
    assign bit_out   = corrected[BCD_W-1];
    assign digit_out = digit_reg;

    always_comb begin
        digit_next = digit_reg;
        if (ctrl.clear) begin
            digit_next = '0;
        end else if (ctrl.dabble) begin
            digit_next = {corrected[BCD_W-2:0], bit_in};
        end else if (ctrl.shift_digit) begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

endmodule

`default_nettype wire

// ===== hdl/b2da_ctrl.sv =====
// Sequencer for the converter: input handshake, conversion and digit
// emission counters, leading zero suppression and the output register.
// Depends on b2da_pkg.
`default_nettype none

module b2da_ctrl (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [b2da_pkg::BCD_W-1:0]   top_digit,
    output b2da_pkg::cell_ctrl_t         cell_ctrl,
    output logic                         load_value,
    output logic                         shift_value,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [b2da_pkg::CHAR_W-1:0]  m_digit_char,
    output logic                         m_is_last
);
    import b2da_pkg::*;

    b2da_state_t          state_reg, state_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0] dig_cnt_reg, dig_cnt_next;
    logic                 seen_nz_reg, seen_nz_next;
    logic                 valid_reg, valid_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 last_reg, last_next;

    logic accept;
    logic final_digit;
    logic show;
    logic step;

    assign accept      = s_valid && s_ready;
    assign final_digit = (dig_cnt_reg == LAST_DIGIT);
    assign show        = seen_nz_reg || (top_digit != '0) || final_digit;
    // A leading zero is dropped without waiting for the output register.
    assign step        = (state_reg == ST_EMIT) && (!show || !valid_reg || m_ready);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                if (bit_cnt_reg == LAST_BIT) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (step && final_digit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath control.
    always_comb begin
        s_ready       = 1'b0;
        load_value    = 1'b0;
        shift_value   = 1'b0;
        cell_ctrl     = '0;
        bit_cnt_next  = bit_cnt_reg;
        dig_cnt_next  = dig_cnt_reg;
        seen_nz_next  = seen_nz_reg;
        valid_next    = valid_reg && !m_ready;
        char_next     = char_reg;
        last_next     = last_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready         = 1'b1;
                load_value      = accept;
                cell_ctrl.clear = accept;
                bit_cnt_next    = '0;
            end
            ST_CONVERT: begin
                shift_value      = 1'b1;
                cell_ctrl.dabble = 1'b1;
                bit_cnt_next     = bit_cnt_reg + 1'b1;
                dig_cnt_next     = '0;
                seen_nz_next     = 1'b0;
            end
            ST_EMIT: begin
                if (step) begin
                    cell_ctrl.shift_digit = 1'b1;
                    dig_cnt_next          = dig_cnt_reg + 1'b1;
                    if (show) begin
                        seen_nz_next = 1'b1;
                        valid_next   = 1'b1;
                        char_next    = ASCII_ZERO + {{(CHAR_W-BCD_W){1'b0}}, top_digit};
                        last_next    = final_digit;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        seen_nz_reg <= seen_nz_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign m_valid      = valid_reg;
    assign m_digit_char = char_reg;
    assign m_is_last    = last_reg;

endmodule

`default_nettype wire

// ===== bench/binary_to_decimal_ascii_top_tb.sv =====
// Self-checking testbench for binary_to_decimal_ascii_top: drives 64-bit words and checks
// every ASCII digit word against a decimal predictor.
// Depends on b2da_pkg and the converter RTL only.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_top_tb;

    import b2da_pkg::*;

    localparam int              HALF_PERIOD    = 5;
    localparam int              RESET_CYCLES   = 12;
    localparam int              LONG_HOLD      = 1500;
    localparam int              WATCHDOG_LIMIT = 20000;
    localparam int              SETTLE_CYCLES  = 100;
    localparam int              REPORT_LIMIT   = 10;
    localparam logic [63:0]     DIGIT_BASE     = 64'd10;
    localparam int              CHAR_ZERO      = 48;

    // One word of the result channel as the predictor sees it.
    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              is_last;
    } digit_word_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [VALUE_W-1:0]  s_value = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [CHAR_W-1:0]   m_digit_char;
    logic                m_is_last;

    // Values waiting to be offered by the driver, and the digits still owed by the block.
    logic [VALUE_W-1:0]  value_backlog[$];
    digit_word_t         digit_queue[$];

    // Idling controls, set per phase by the stimulus process.
    bit                  tx_idle_on = 1'b0;
    bit                  rx_idle_on = 1'b0;
    bit                  rx_hold_req = 1'b0;

    int                  tx_gap = 0;
    int                  rx_gap = 0;
    int                  rx_hold_left = 0;
    int                  quiet_cycles = 0;

    int                  values_sent = 0;
    int                  digits_checked = 0;
    int                  mismatch_count = 0;
    int                  longest_run = 0;
    int                  full_runs = 0;

    binary_to_decimal_ascii_top DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_is_last    (m_is_last)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Breaks the value into decimal digits, least significant first, then queues them
    // most significant first as ASCII. The loop runs at least once, so zero gives '0'.
    function automatic void queue_decimal_digits(input logic [VALUE_W-1:0] value);
        logic [3:0]         rev[NUM_DIGITS];
        logic [VALUE_W-1:0] rest;
        int                 n;
        digit_word_t        w;
        rest = value;
        n = 0;
        do begin
            rev[n] = 4'(rest % DIGIT_BASE);
            rest = rest / DIGIT_BASE;
            n++;
        end while (rest != 0 && n < NUM_DIGITS);
        for (int k = n - 1; k >= 0; k--) begin
            w.digit_char = CHAR_W'(CHAR_ZERO + rev[k]);
            w.is_last    = (k == 0);
            digit_queue.push_back(w);
        end
        if (n > longest_run) begin
            longest_run = n;
        end
        if (n == NUM_DIGITS) begin
            full_runs++;
        end
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap(input bit on);
        int r;
        if (!on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(8, 40);
        end
    endfunction

    // Spreads the values over every digit count: shifted full-width words give all
    // magnitudes, powers of ten and their neighbors hit the digit-count boundaries.
    function automatic logic [VALUE_W-1:0] random_value();
        int                 pick;
        int                 e;
        logic [VALUE_W-1:0] p;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            return '0;
        end else if (pick < 10) begin
            return '1;
        end else if (pick < 32) begin
            e = $urandom_range(0, NUM_DIGITS - 1);
            p = 64'd1;
            repeat (e) p = p * DIGIT_BASE;
            case ($urandom_range(0, 2))
                0: return p;
                1: return p - 64'd1;
                default: return p + 64'd1;
            endcase
        end else begin
            return {$urandom(), $urandom()} >> $urandom_range(0, VALUE_W - 1);
        end
    endfunction

    // Driver. The payload is held until accepted; after each accepted word the sender
    // may idle for a random gap before offering the next one from the backlog.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_value <= '0;
            tx_gap  <= 0;
        end else if (s_valid && !s_ready) begin
            // Still waiting for the block to take the current word.
        end else begin
            int gap_now;
            gap_now = tx_gap;
            if (s_valid) begin
                queue_decimal_digits(s_value);
                values_sent++;
                gap_now = pick_gap(tx_idle_on);
            end
            if (gap_now > 0) begin
                s_valid <= 1'b0;
                tx_gap  <= gap_now - 1;
            end else if (value_backlog.size() != 0) begin
                s_valid <= 1'b1;
                s_value <= value_backlog.pop_front();
                tx_gap  <= 0;
            end else begin
                s_valid <= 1'b0;
                tx_gap  <= 0;
            end
        end
    end

    // Monitor and receiver. Each accepted digit word is compared with the oldest
    // prediction. Ready then drops for a random stall, or for the long hold when the
    // stimulus process has asked for one; the hold is counted down here.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            digit_word_t want;
            int          hold_now;
            int          gap_now;
            hold_now = rx_hold_left;
            gap_now  = rx_gap;
            if (m_valid && m_ready) begin
                digits_checked++;
                if (digit_queue.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected digit word: char %0d last %0b",
                                 $realtime, m_digit_char, m_is_last);
                    end
                end else begin
                    want = digit_queue.pop_front();
                    if (m_digit_char !== want.digit_char || m_is_last !== want.is_last) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("%0t: digit mismatch: want %0d last %0b, got %0d last %0b",
                                     $realtime, want.digit_char, want.is_last,
                                     m_digit_char, m_is_last);
                        end
                    end
                end
                gap_now = pick_gap(rx_idle_on);
            end
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_now = LONG_HOLD;
            end
            if (hold_now > 0) begin
                m_ready      <= 1'b0;
                rx_hold_left <= hold_now - 1;
                rx_gap       <= gap_now;
            end else if (gap_now > 0) begin
                m_ready      <= 1'b0;
                rx_hold_left <= 0;
                rx_gap       <= gap_now - 1;
            end else begin
                m_ready      <= 1'b1;
                rx_hold_left <= 0;
                rx_gap       <= 0;
            end
        end
    end

    // Watchdog: too many cycles in a row with no word moving on either channel
    // means the block has hung.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $realtime, quiet_cycles);
                $display("tb: failure");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // The stimulus process works on falling edges so that its backlog and control
    // updates never race the clocked driver and receiver.
    task automatic wait_drained();
        do @(negedge aclk);
        while (value_backlog.size() != 0 || s_valid || digit_queue.size() != 0);
    endtask

    task automatic add_random_values(input int count);
        repeat (count) value_backlog.push_back(random_value());
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed words with no idling: zero, single digits, every digit-count
        // boundary near the top, the largest value with its 20-digit run, and
        // alternating bit patterns.
        value_backlog.push_back(64'd0);
        value_backlog.push_back(64'd1);
        value_backlog.push_back(64'd9);
        value_backlog.push_back(64'd10);
        value_backlog.push_back(64'd99);
        value_backlog.push_back(64'd100);
        value_backlog.push_back(64'd9876543210);
        value_backlog.push_back(64'd4294967295);
        value_backlog.push_back(64'd4294967296);
        value_backlog.push_back(64'd999999999999999999);
        value_backlog.push_back(64'd1000000000000000000);
        value_backlog.push_back(64'd9999999999999999999);
        value_backlog.push_back(64'd10000000000000000000);
        value_backlog.push_back(64'd12345678901234567890);
        value_backlog.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        value_backlog.push_back(64'h8000_0000_0000_0000);
        value_backlog.push_back(64'h5555_5555_5555_5555);
        value_backlog.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        value_backlog.push_back(64'hFFFF_FFFF_FFFF_FFFE);
        value_backlog.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        // The stimulus pauses here until every digit has come back.
        wait_drained();

        // Random words with idling on both sides.
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        add_random_values(140);
        wait_drained();

        // Backpressure: the receiver holds off for a long stretch while the sender
        // keeps offering back to back, so the block fills and stalls its input.
        tx_idle_on = 1'b0;
        rx_hold_req = 1'b1;
        value_backlog.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        add_random_values(7);
        wait_drained();

        // A stretch with no idling at all, then more random traffic with idling.
        rx_idle_on = 1'b0;
        add_random_values(60);
        wait_drained();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        add_random_values(140);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (digit_queue.size() != 0) begin
            mismatch_count += digit_queue.size();
            $display("%0d predicted digit words never arrived", digit_queue.size());
        end

        $display("summary: %0d values converted, %0d digit words checked, %0d mismatches",
                 values_sent, digits_checked, mismatch_count);
        $display("summary: longest run %0d digits, %0d full-length runs, long receiver hold done",
                 longest_run, full_runs);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
